// ===== design/mavg_pkg.sv =====
package mavg_pkg;

  // configuration register file
  localparam int WIDTH_REG_W = 9;
  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 9'd50;
  localparam logic MODE_RESET = 1'b0;

  // register indexes on the configuration port
  localparam logic CFG_IDX_WIDTH = 1'b0;
  localparam logic CFG_IDX_MODE  = 1'b1;

  // filter modes
  localparam logic MODE_LOW_PASS  = 1'b0;
  localparam logic MODE_HIGH_PASS = 1'b1;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0] window_width;
    logic                   filter_mode;
  } cfg_t;

endpackage

// ===== design/mavg_ram.sv =====
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the slot written in the same cycle returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mavg_queue.sv =====
module mavg_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             not_empty,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign rdata     = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/mavg_front.sv =====
module mavg_front import mavg_pkg::*; #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int QW          = 52
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [QW-1:0]          q_wdata
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int EW    = (CNT_W > WIDTH_REG_W) ? CNT_W : WIDTH_REG_W;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_UPD  = 1'b1;

  logic                   state;
  logic [SUM_W-1:0]       running_sum;
  logic [CNT_W-1:0]       fill_count;
  logic [PTR_W-1:0]       write_pointer;

  // item held between accept and update
  logic [SAMPLE_BITS-1:0] cur_sample;
  logic                   cur_drop;
  logic [CNT_W-1:0]       cur_w;
  logic                   cur_mode;
  logic                   cur_full;

  logic                   accept;
  logic [EW-1:0]          w_ext;
  logic [CNT_W-1:0]       eff_w;
  logic                   drop;
  logic [CNT_W-1:0]       fill_next;
  logic [PTR_W:0]         old_raw;
  logic [PTR_W-1:0]       old_idx;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]       add_term;
  logic [SUM_W-1:0]       sub_term;
  logic [SUM_W-1:0]       sum_next;

  assign in_ready = (state == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;

  // effective width, clamped to one and to the delay line depth
  assign w_ext = EW'(cfg.window_width);
  always_comb begin
    if (w_ext == '0) begin
      eff_w = CNT_W'(1);
    end else if (w_ext > EW'(MAX_WINDOW)) begin
      eff_w = CNT_W'(MAX_WINDOW);
    end else begin
      eff_w = w_ext[CNT_W-1:0];
    end
  end

  // window bookkeeping
  assign drop      = (fill_count >= eff_w);
  assign fill_next = drop ? fill_count : fill_count + 1'b1;

  // slot of the oldest held sample
  assign old_raw = {1'b0, write_pointer} + (PTR_W+1)'(MAX_WINDOW) - (PTR_W+1)'(fill_count);
  assign old_idx = (old_raw >= (PTR_W+1)'(MAX_WINDOW)) ?
                   PTR_W'(old_raw - (PTR_W+1)'(MAX_WINDOW)) : old_raw[PTR_W-1:0];

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_delay_line (
    .clk   (clk),
    .we    (accept),
    .waddr (write_pointer),
    .wdata (in_sample),
    .raddr (old_idx),
    .rdata (old_sample)
  );

  // running sum update once the oldest sample is read
  assign add_term = {{CNT_W{cur_sample[SAMPLE_BITS-1]}}, cur_sample};
  assign sub_term = cur_drop ? {{CNT_W{old_sample[SAMPLE_BITS-1]}}, old_sample} : '0;
  assign sum_next = running_sum + add_term - sub_term;

  assign q_push  = (state == F_UPD);
  assign q_wdata = {cur_sample, sum_next, cur_w, cur_mode, cur_full};

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_sample <= in_sample;
      cur_drop   <= drop;
      cur_w      <= eff_w;
      cur_mode   <= cfg.filter_mode;
      cur_full   <= (fill_next == eff_w);
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= F_IDLE;
      running_sum   <= '0;
      fill_count    <= '0;
      write_pointer <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            fill_count    <= fill_next;
            write_pointer <= (write_pointer == PTR_W'(MAX_WINDOW - 1)) ?
                             '0 : write_pointer + 1'b1;
            state         <= F_UPD;
          end
        end
        F_UPD: begin
          running_sum <= sum_next;
          state       <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== design/mavg_back.sv =====
module mavg_back import mavg_pkg::*; #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16,
  parameter int QW          = 52
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_not_empty,
  input  logic [QW-1:0]        q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_BITS:0] out_filtered,
  output logic                 out_full
);

  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + CNT_W;
  localparam int OUT_W = SAMPLE_BITS + 1;
  localparam int DC_W  = $clog2(SUM_W);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_FIN  = 2'd2;

  logic [1:0]             state;
  logic [DC_W-1:0]        step_cnt;

  // fields of the queue head
  logic [SAMPLE_BITS-1:0] e_sample;
  logic [SUM_W-1:0]       e_sum;
  logic [CNT_W-1:0]       e_w;
  logic                   e_mode;
  logic                   e_full;

  // item under division
  logic [SAMPLE_BITS-1:0] d_sample;
  logic                   d_neg;
  logic [CNT_W-1:0]       d_w;
  logic                   d_mode;
  logic                   d_full;
  logic [CNT_W-1:0]       rem;
  logic [SUM_W-1:0]       quo;

  logic [CNT_W:0]         rem_sh;
  logic                   q_bit;
  logic [SUM_W-1:0]       quo_signed;
  logic [SUM_W:0]         result;
  logic                   load_out;

  assign {e_sample, e_sum, e_w, e_mode, e_full} = q_rdata;

  assign q_pop = (state == B_IDLE) && q_not_empty;

  // one restoring step per cycle on the magnitude of the sum
  assign rem_sh = {rem, quo[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, d_w});

  // sign fix-up and high-pass subtraction
  assign quo_signed = d_neg ? -quo : quo;
  always_comb begin
    if (d_mode == MODE_HIGH_PASS) begin
      result = {{(SUM_W+1-SAMPLE_BITS){d_sample[SAMPLE_BITS-1]}}, d_sample}
             - {quo_signed[SUM_W-1], quo_signed};
    end else begin
      result = {quo_signed[SUM_W-1], quo_signed};
    end
  end

  assign load_out = (state == B_FIN) && (!out_valid || out_ready);

  // divider datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      d_sample <= e_sample;
      d_neg    <= e_sum[SUM_W-1];
      d_w      <= e_w;
      d_mode   <= e_mode;
      d_full   <= e_full;
      rem      <= '0;
      quo      <= e_sum[SUM_W-1] ? -e_sum : e_sum;
    end else if (state == B_DIV) begin
      rem <= q_bit ? CNT_W'(rem_sh - {1'b0, d_w}) : rem_sh[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], q_bit};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_filtered <= result[OUT_W-1:0];
      out_full     <= d_full;
    end
  end

  // sequencer and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (q_pop) begin
            step_cnt <= DC_W'(SUM_W - 1);
            state    <= B_DIV;
          end
        end
        B_DIV: begin
          if (step_cnt == '0) begin
            state <= B_FIN;
          end else begin
            step_cnt <= step_cnt - 1'b1;
          end
        end
        B_FIN: begin
          if (load_out) begin
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== design/moving_average_low_high_pass.sv =====
// moving average filter, low-pass average or high-pass sample minus average
// data path: the front end updates the running sum, the queue holds the item, the back end divides
//   one quotient bit per cycle and loads the output register; it pops a new item only once the last
//   is loaded out, and the front accepts a sample only while idle with room in the queue
// reset: rst is synchronous, clears sum, fill count, write pointer, queue and handshakes,
//   and restores window_width 50 and filter_mode low-pass; the delay line is not cleared
module moving_average_low_high_pass import mavg_pkg::*; #(
  parameter int MAX_WINDOW  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // slave side: tdata = sample
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
  // master side: tdata = filtered; tuser = window_full
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((SAMPLE_BITS+8)/8)*8-1:0]       m_tdata,
  output logic                                   m_tuser,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic                                   cfg_index,
  input  logic [WIDTH_REG_W-1:0]                 cfg_data
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int QW     = SAMPLE_BITS + SUM_W + CNT_W + 2;
  localparam int OUT_TW = ((SAMPLE_BITS + 8) / 8) * 8;

  cfg_t                 cfg;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_not_empty;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  logic [SAMPLE_BITS:0] out_filtered;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_width <= WIDTH_RESET;
      cfg.filter_mode  <= MODE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH: cfg.window_width <= cfg_data;
        CFG_IDX_MODE:  cfg.filter_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mavg_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .QW          (QW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata[SAMPLE_BITS-1:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  mavg_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .rdata     (q_rdata),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  mavg_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .QW          (QW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_filtered (out_filtered),
    .out_full     (m_tuser)
  );

  assign m_tdata = OUT_TW'(out_filtered);

endmodule

// ===== bench/tb_moving_average_low_high_pass.sv =====
module tb_moving_average_low_high_pass;
  import mavg_pkg::*;

  localparam int DEPTH  = 256;
  localparam int SBITS  = 16;
  localparam int SD_W   = ((SBITS+7)/8)*8;
  localparam int MD_W   = ((SBITS+8)/8)*8;
  localparam int ITEMS  = 1650;
  localparam int LIMIT  = 600000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [SBITS:0] filtered;
    logic           full;
  } out_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [SD_W-1:0]        s_tdata = '0;     // sample
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [MD_W-1:0]        m_tdata;          // filtered
  logic                   m_tuser;          // window_full
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = CFG_IDX_WIDTH;
  logic [WIDTH_REG_W-1:0] cfg_data = '0;

  moving_average_low_high_pass dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // filter state mirrored on the bench side
  logic [WIDTH_REG_W-1:0] width_reg = WIDTH_RESET;
  logic                   mode_reg  = MODE_RESET;
  int                     taps [DEPTH];
  int                     tap_sum = 0;
  int                     held = 0;
  int                     wr_ptr = 0;

  out_beat_t        filtered_q [$];
  logic [SBITS-1:0] sample_q [$];
  out_beat_t        want;

  bit burst = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int recv_draw;
  int n_in = 0, n_out = 0, n_full = 0, n_high = 0, n_cfg = 0, n_bad = 0;
  int cycle_cnt = 0;

  // width zero acts as one, anything past the delay line saturates
  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > DEPTH) return DEPTH;
    return int'(width_reg);
  endfunction

  // running sum update and average for one accepted sample
  task automatic filter_sample(input logic signed [SBITS-1:0] s);
    int        w;
    int        avg;
    int        res;
    out_beat_t b;
    w = eff_width();
    tap_sum += int'(s);
    // oldest sample leaves only once the window overflows, one per sample at most
    if (held + 1 > w) tap_sum -= taps[(wr_ptr + DEPTH - held) % DEPTH];
    else held++;
    taps[wr_ptr] = int'(s);
    wr_ptr = (wr_ptr + 1) % DEPTH;
    avg = tap_sum / w;
    res = (mode_reg == MODE_HIGH_PASS) ? int'(s) - avg : avg;
    b.filtered = res[SBITS:0];
    b.full = (held == w);
    filtered_q = {filtered_q, b};
    if (b.full) n_full++;
    if (mode_reg == MODE_HIGH_PASS) n_high++;
  endtask

  // register write, only issued while the filter is idle
  task automatic write_reg(input logic idx, input logic [WIDTH_REG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_WIDTH) width_reg = val;
    else mode_reg = val[0];
    n_cfg++;
  endtask

  // hold off until every queued sample is out and every result is back
  task automatic settle();
    while (sample_q.size() > 0 || s_tvalid || filtered_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sample source: one beat per queued sample, random gap after each outside bursts
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        filter_sample(s_tdata[SBITS-1:0]);
        n_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          s_tdata  <= SD_W'(sample_q[0]);
          sample_q.delete(0);
          s_tvalid <= 1'b1;
          send_gap <= burst ? 0 : $urandom_range(0, 7);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result sink: compare each beat with the oldest expected result
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_out++;
        if (filtered_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected beat: filtered %0d full %0b",
                     $signed(m_tdata[SBITS:0]), m_tuser);
        end else begin
          want = filtered_q[0];
          filtered_q.delete(0);
          if (m_tdata[SBITS:0] !== want.filtered || m_tuser !== want.full) begin
            n_bad++;
            if (n_bad <= 10)
              $display("beat %0d: filtered %0d full %0b, expected %0d full %0b",
                       n_out, $signed(m_tdata[SBITS:0]), m_tuser,
                       $signed(want.filtered), want.full);
          end
        end
        recv_draw = burst ? 0 : $urandom_range(0, 7);
        recv_stall <= recv_draw;
        m_tready   <= (recv_draw == 0);
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        m_tready   <= (recv_stall == 1);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("no progress, stopped after %0d cycles", LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int r;
    int wv;
    int cur_w;
    int len;
    int kind;
    int base;
    int v;
    int pushed;
    int n_phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset configuration, sample extremes
    sample_q = {sample_q, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
    settle();

    // width zero, held count stays above the width, high-pass
    write_reg(CFG_IDX_WIDTH, '0);
    write_reg(CFG_IDX_MODE, WIDTH_REG_W'(MODE_HIGH_PASS));
    sample_q = {sample_q, 16'h7FFF, 16'h8000, 16'h2AAA};
    settle();

    // width one, low-pass
    write_reg(CFG_IDX_WIDTH, 9'd1);
    write_reg(CFG_IDX_MODE, WIDTH_REG_W'(MODE_LOW_PASS));
    sample_q = {sample_q, 16'h8000, 16'h8000, 16'h7FFF};
    settle();

    // window grown to eight, fills and then slides
    write_reg(CFG_IDX_WIDTH, 9'd8);
    sample_q = {sample_q, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001};
    settle();

    // width past the delay line depth, high-pass
    write_reg(CFG_IDX_WIDTH, 9'h1FF);
    write_reg(CFG_IDX_MODE, WIDTH_REG_W'(MODE_HIGH_PASS));
    sample_q = {sample_q, 16'h8000, 16'h7FFF, 16'h0000, 16'hAAAA};
    settle();

    // random phases: width mostly grows so the window keeps filling,
    // with some shrinks and late saturating widths; every other phase
    // keeps the width and mode of the phase before and sends samples
    cur_w = 12;
    pushed = 0;
    n_phase = 0;
    while (pushed < ITEMS) begin
      n_phase++;
      burst = ($urandom_range(0, 3) == 0);
      if (n_phase % 2 == 1) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          wv = $urandom_range(0, cur_w);
        end else if (r == 1 && pushed > 1200) begin
          wv = $urandom_range(257, 511);
        end else begin
          wv = cur_w + $urandom_range(0, 24);
          if (wv > DEPTH) wv = DEPTH;
        end
        if (wv >= 1 && wv <= DEPTH) cur_w = wv;
        write_reg(CFG_IDX_WIDTH, wv[WIDTH_REG_W-1:0]);
        write_reg(CFG_IDX_MODE, $urandom_range(0, 1) ? WIDTH_REG_W'(MODE_HIGH_PASS)
                                                     : WIDTH_REG_W'(MODE_LOW_PASS));
      end
      len = (eff_width() > held ? eff_width() - held : 0) + $urandom_range(4, 40);
      if (len > ITEMS - pushed) len = ITEMS - pushed;
      kind = $urandom_range(0, 9);
      base = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < len; i++) begin
        case (kind)
          6: v = $urandom_range(0, 1) ? 32767 : -32768;
          7: v = $urandom_range(0, 8) - 4;
          8: v = base;
          9: v = base + i * 257;
          default: v = $urandom_range(0, 65535);
        endcase
        sample_q = {sample_q, v[SBITS-1:0]};
      end
      pushed += len;
      settle();
    end

    $display("%0d samples filtered, %0d results checked, %0d register writes",
             n_in, n_out, n_cfg);
    $display("%0d results with a full window, %0d in high-pass mode", n_full, n_high);
    if (n_bad == 0 && filtered_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_bad, filtered_q.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
